/* rtl/cd_track_subcode_generator_defines.svh */
// Assertion macros shared by the CD track subcode generator RTL.
`ifndef CD_TRACK_SUBCODE_GENERATOR_DEFINES_SVH
`define CD_TRACK_SUBCODE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define CTSG_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ctsg assertion failed");
// Check a property on every clock edge, reset included.
`define CTSG_ASSERT_ALWAYS(name, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("ctsg assertion failed");
`else
`define CTSG_ASSERT(name, prop)
`define CTSG_ASSERT_ALWAYS(name, prop)
`endif

`endif

/* rtl/ctsg_pkg.sv */
// Types, constants and helper functions of the CD track subcode generator.
package ctsg_pkg;

	localparam int MAX_TRACKS_DEF = 100;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [6:0] CTRL_AUDIO = 7'h01;
	localparam logic [6:0] CTRL_DATA  = 7'h41;

	// Frame counts carry one bit more than a sector address: sector plus lead-in can wrap 19 bits.
	localparam int TIME_W         = 20;
	localparam int LEAD_IN        = 150;
	localparam int FRAMES_PER_SEC = 75;
	localparam int FRAMES_PER_MIN = 60 * 75;

	// Reciprocals for exact constant division: t / 4500 for any 20-bit t,
	// r / 75 for any 13-bit r.
	localparam int MIN_RECIP = 477219;
	localparam int MIN_SHIFT = 31;
	localparam int SEC_RECIP = 6991;
	localparam int SEC_SHIFT = 19;

	typedef struct packed {
		logic [6:0]  number;
		logic        audio;
		logic [18:0] first_lba;
		logic [18:0] end_lba;
	} entry_t;

	// Packed BCD of a 7-bit value; tens digit may exceed 9.
	function automatic logic [7:0] bcd8(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  units;
		prod  = 15'(v) * 15'd205;
		tens  = prod[14:11];
		units = v - 7'({3'b000, tens} * 7'd10);
		return {tens, units[3:0]};
	endfunction

	// Whole minutes in a frame count.
	function automatic logic [6:0] frames_to_min(input logic [TIME_W-1:0] t);
		logic [38:0] prod;
		prod = 39'(t) * 39'(MIN_RECIP);
		return prod[MIN_SHIFT+6:MIN_SHIFT];
	endfunction

	// Whole seconds in a frame count below one minute.
	function automatic logic [5:0] frames_to_sec(input logic [12:0] r);
		logic [25:0] prod;
		prod = 26'(r) * 26'(SEC_RECIP);
		return prod[SEC_SHIFT+5:SEC_SHIFT];
	endfunction

endpackage

/* rtl/cd_track_subcode_generator.sv */
// CD track table and Q-subchannel position generator, top level.
//
// The block keeps a table of up to MAX_TRACKS CD tracks in a one-port-write,
// one-port-read synchronous memory with a registered read. A load transaction
// (mode 0) writes one slot and gives no result; a slot at or above MAX_TRACKS
// is dropped. A query transaction (mode 1) scans slots from 0 upward, one
// memory read per cycle, below min(track_count, MAX_TRACKS), and stops at the
// first slot whose [start, end) range holds the sector. A hit then runs a
// conversion on the relative time (sector minus track start) and, in parallel,
// the absolute time (sector plus 150): minutes by reciprocal multiplication for
// 4500, the minute remainder, seconds by reciprocal multiplication for 75, and
// the second remainder giving frames. A miss returns found = 0 with every field
// zero. The block takes one transaction at a time; the output register holds a
// finished result while the block accepts the next transaction. Loads are taken
// only when the block is idle, so a scan never reads a slot that is being
// written. The table has no reset and no clearing pass: a query must only
// reach slots that were loaded. The user must write track_count through the
// cfg port only while the block is idle, which the block itself leaves
// unenforced; cfg_ready is always high.
module cd_track_subcode_generator #(
	parameter int MAX_TRACKS = ctsg_pkg::MAX_TRACKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	// input transactions
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [6:0]  slot,
	input  logic [6:0]  track_number,
	input  logic        track_audio,
	input  logic [18:0] track_start,
	input  logic [18:0] track_end,
	input  logic [18:0] query_lba,
	// result transactions
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic        is_audio,
	output logic [6:0]  control_byte,
	output logic [7:0]  track_bcd,
	output logic        index_bcd,
	output logic [7:0]  rel_min_bcd,
	output logic [6:0]  rel_sec_bcd,
	output logic [6:0]  rel_frame_bcd,
	output logic [7:0]  abs_min_bcd,
	output logic [6:0]  abs_sec_bcd,
	output logic [6:0]  abs_frame_bcd
);
	import ctsg_pkg::*;

	`include "cd_track_subcode_generator_defines.svh"

	// Address width of the table and width of the scan counter, which must reach the limit.
	localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CW = $clog2(MAX_TRACKS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_CONV = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	// Conversion steps
	localparam logic [1:0] STEP_MIN     = 2'd0;
	localparam logic [1:0] STEP_MIN_REM = 2'd1;
	localparam logic [1:0] STEP_SEC     = 2'd2;
	localparam logic [1:0] STEP_SEC_REM = 2'd3;

	// Track table
	entry_t mem [MAX_TRACKS];
	entry_t rd_data_s1;

	// Control state
	logic [1:0]    state_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] limit_q;
	logic          rd_vld_s1;
	logic [1:0]    step_q;
	logic          hit_q;
	logic          out_valid_q;
	logic [6:0]    track_count_q;

	// Datapath registers
	logic [18:0]       lba_q;
	entry_t            ent_q;
	logic [TIME_W-1:0] rel_rem_q;
	logic [TIME_W-1:0] abs_rem_q;
	logic [6:0]        rel_min_q;
	logic [6:0]        abs_min_q;
	logic [5:0]        rel_sec_q;
	logic [5:0]        abs_sec_q;

	// Result register
	logic        found_q;
	logic        is_audio_q;
	logic [6:0]  control_byte_q;
	logic [7:0]  track_bcd_q;
	logic        index_bcd_q;
	logic [7:0]  rel_min_bcd_q;
	logic [6:0]  rel_sec_bcd_q;
	logic [6:0]  rel_frame_bcd_q;
	logic [7:0]  abs_min_bcd_q;
	logic [6:0]  abs_sec_bcd_q;
	logic [6:0]  abs_frame_bcd_q;

	logic          in_fire;
	logic          load_fire;
	logic          query_fire;
	logic          slot_ok;
	logic [7:0]    count_ext;
	logic [7:0]    limit_ext;
	logic [CW-1:0] limit_w;
	logic          issue_ok;
	logic          rd_hit;
	logic          scan_miss;
	logic          out_free;
	logic          resp_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign load_fire  = in_fire && (mode == MODE_LOAD);
	assign query_fire = in_fire && (mode == MODE_QUERY);
	assign slot_ok    = ({1'b0, slot} < 8'(MAX_TRACKS));

	// Clamp the search limit to the table depth.
	assign count_ext = {1'b0, track_count_q};
	assign limit_ext = (count_ext > 8'(MAX_TRACKS)) ? 8'(MAX_TRACKS) : count_ext;
	assign limit_w   = limit_ext[CW-1:0];

	// Scan: issue a read while slots remain, compare the entry returned in the next cycle.
	assign issue_ok  = (rd_idx_q < limit_q);
	assign rd_hit    = rd_vld_s1 && (lba_q >= rd_data_s1.first_lba)
		&& (lba_q < rd_data_s1.end_lba);
	assign scan_miss = !rd_vld_s1 && !issue_ok;

	assign out_free  = !out_valid_q || out_ready;
	assign resp_load = (state_q == ST_RESP) && out_free;

	// Table write and registered read
	always_ff @(posedge clk) begin
		if (load_fire && slot_ok) begin
			mem[slot[AW-1:0]] <= '{number: track_number, audio: track_audio,
				first_lba: track_start, end_lba: track_end};
		end
		rd_data_s1 <= mem[rd_idx_q[AW-1:0]];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_idx_q      <= '0;
			limit_q       <= '0;
			rd_vld_s1     <= 1'b0;
			step_q        <= STEP_MIN;
			hit_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			track_count_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				track_count_q <= cfg_data;
			end
			rd_vld_s1 <= (state_q == ST_SCAN) && issue_ok && !rd_hit;
			// Raise valid when a result is loaded, drop it once taken.
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (query_fire) begin
						rd_idx_q <= '0;
						limit_q  <= limit_w;
						hit_q    <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_hit) begin
						hit_q   <= 1'b1;
						step_q  <= STEP_MIN;
						state_q <= ST_CONV;
					end else if (scan_miss) begin
						state_q <= ST_RESP;
					end
					if (issue_ok && !rd_hit) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_CONV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_SEC_REM) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: capture the query, the matching entry, and split both times.
	always_ff @(posedge clk) begin
		if (query_fire) begin
			lba_q <= query_lba;
		end
		if ((state_q == ST_SCAN) && rd_hit) begin
			ent_q     <= rd_data_s1;
			rel_rem_q <= {1'b0, lba_q} - {1'b0, rd_data_s1.first_lba};
			abs_rem_q <= {1'b0, lba_q} + TIME_W'(LEAD_IN);
		end
		if (state_q == ST_CONV) begin
			case (step_q)
				STEP_MIN: begin
					rel_min_q <= frames_to_min(rel_rem_q);
					abs_min_q <= frames_to_min(abs_rem_q);
				end
				STEP_MIN_REM: begin
					rel_rem_q <= rel_rem_q - (TIME_W'(rel_min_q) * TIME_W'(FRAMES_PER_MIN));
					abs_rem_q <= abs_rem_q - (TIME_W'(abs_min_q) * TIME_W'(FRAMES_PER_MIN));
				end
				STEP_SEC: begin
					rel_sec_q <= frames_to_sec(rel_rem_q[12:0]);
					abs_sec_q <= frames_to_sec(abs_rem_q[12:0]);
				end
				STEP_SEC_REM: begin
					rel_rem_q <= rel_rem_q - (TIME_W'(rel_sec_q) * TIME_W'(FRAMES_PER_SEC));
					abs_rem_q <= abs_rem_q - (TIME_W'(abs_sec_q) * TIME_W'(FRAMES_PER_SEC));
				end
				default: begin
				end
			endcase
		end
		if (resp_load) begin
			found_q     <= hit_q;
			index_bcd_q <= hit_q;
			if (hit_q) begin
				is_audio_q      <= ent_q.audio;
				control_byte_q  <= ent_q.audio ? CTRL_AUDIO : CTRL_DATA;
				track_bcd_q     <= bcd8(ent_q.number);
				rel_min_bcd_q   <= bcd8(rel_min_q);
				rel_sec_bcd_q   <= 7'(bcd8({1'b0, rel_sec_q}));
				rel_frame_bcd_q <= 7'(bcd8(rel_rem_q[6:0]));
				abs_min_bcd_q   <= bcd8(abs_min_q);
				abs_sec_bcd_q   <= 7'(bcd8({1'b0, abs_sec_q}));
				abs_frame_bcd_q <= 7'(bcd8(abs_rem_q[6:0]));
			end else begin
				is_audio_q      <= 1'b0;
				control_byte_q  <= '0;
				track_bcd_q     <= '0;
				rel_min_bcd_q   <= '0;
				rel_sec_bcd_q   <= '0;
				rel_frame_bcd_q <= '0;
				abs_min_bcd_q   <= '0;
				abs_sec_bcd_q   <= '0;
				abs_frame_bcd_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign is_audio      = is_audio_q;
	assign control_byte  = control_byte_q;
	assign track_bcd     = track_bcd_q;
	assign index_bcd     = index_bcd_q;
	assign rel_min_bcd   = rel_min_bcd_q;
	assign rel_sec_bcd   = rel_sec_bcd_q;
	assign rel_frame_bcd = rel_frame_bcd_q;
	assign abs_min_bcd   = abs_min_bcd_q;
	assign abs_sec_bcd   = abs_sec_bcd_q;
	assign abs_frame_bcd = abs_frame_bcd_q;

	// The compare stage is live only inside a scan.
	`CTSG_ASSERT(a_cmp_in_scan, rd_vld_s1 |-> (state_q == ST_SCAN))
	// The scan pointer never runs past the search limit.
	`CTSG_ASSERT(a_idx_bounded, (state_q == ST_SCAN) |-> (rd_idx_q <= limit_q))
	// Conversion only follows a table hit.
	`CTSG_ASSERT(a_conv_after_hit, (state_q == ST_CONV) |-> hit_q)
	// A query takes the block out of idle.
	`CTSG_ASSERT(a_query_busy, (in_valid && in_ready && (mode == MODE_QUERY)) |=> !in_ready)
	// A hit carries index 1 and one of the two control codes.
	`CTSG_ASSERT(a_hit_fields, (out_valid && found) |-> (index_bcd
		&& ((control_byte == CTRL_AUDIO) || (control_byte == CTRL_DATA))))

endmodule
